// File: sv/swod_pkg.sv
// shared types and constants for the sliding window overload detector
package swod_pkg;

    localparam int EVT_TIME_W  = 64;
    localparam int WINDOW_W    = 32;
    localparam int LIMIT_W     = 3;
    localparam int RCOUNT_W    = 4;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic REG_WINDOW_LENGTH  = 1'b0;
    localparam logic REG_OVERLOAD_LIMIT = 1'b1;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd1000;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 3'd4;

    typedef enum logic [1:0] {
        ST_RECORDED = 2'd0,
        ST_KILLED   = 2'd1,
        ST_IGNORED  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DECIDE
    } state_t;

    typedef struct packed {
        logic [WINDOW_W-1:0] window_length;
        logic [LIMIT_W-1:0]  overload_limit;
    } cfg_t;

endpackage

// File: sv/sliding_window_overload_detector.sv
// top level of the sliding window overload detector
//
// s_ channel: one beat per dropped request, carrying its 64-bit timestamp.
// m_ channel: one beat per input beat, with status (recorded, killed,
// ignored) and the number of events held in the window afterwards.
// apb port: window_length at 0x0, overload_limit at 0x4; write while idle.
//
// an input beat first walks the ring from the oldest entry, retiring one
// expired timestamp per cycle, then decides and pushes its timestamp unless
// the ring is full or the kill flag is set; once the kill flag is set, the
// walk is skipped. the walk retires r entries (0 to RING_DEPTH), one at a
// time through the single-read ring memory. s_ready rises together with
// m_valid, and the next beat is taken while s_ready is high.
// the result register frees the input side while a result waits; if the
// receiver stalls, the next beat is taken and held in the decide step until
// the result register empties.
// reset empties the ring, clears the kill flag and restores the registers
// to window 1000 and limit 4; no clearing pass is needed.
module sliding_window_overload_detector #(
    parameter int RING_DEPTH = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [swod_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [swod_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [swod_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [swod_pkg::EVT_TIME_W-1:0]   s_event_time,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic [swod_pkg::RCOUNT_W-1:0]     m_recent_count
);
    import swod_pkg::*;

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);

    cfg_t                  cfg;
    logic                  mem_we;
    logic [PTR_W-1:0]      mem_waddr;
    logic [EVT_TIME_W-1:0] mem_wdata;
    logic [PTR_W-1:0]      mem_raddr;
    logic [EVT_TIME_W-1:0] mem_rdata;

    assign pready = 1'b1;

    swod_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    swod_ring_mem #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ring (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    swod_ctrl #(
        .RING_DEPTH (RING_DEPTH),
        .PTR_W      (PTR_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_event_time   (s_event_time),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_recent_count (m_recent_count),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata)
    );

endmodule

// File: sv/swod_cfg_regs.sv
// apb configuration registers: window length and overload limit
module swod_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [swod_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [swod_pkg::APB_DATA_W-1:0] pwdata,
    output logic [swod_pkg::APB_DATA_W-1:0] prdata,
    output swod_pkg::cfg_t                 cfg
);
    import swod_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign wr_en = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[2])
                REG_WINDOW_LENGTH:  cfg_next.window_length  = pwdata[WINDOW_W-1:0];
                REG_OVERLOAD_LIMIT: cfg_next.overload_limit = pwdata[LIMIT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_length  <= WINDOW_RESET;
            cfg_reg.overload_limit <= LIMIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WINDOW_LENGTH:  prdata = cfg_reg.window_length;
            REG_OVERLOAD_LIMIT: prdata = {{(APB_DATA_W-LIMIT_W){1'b0}},
                                          cfg_reg.overload_limit};
            default:            prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/swod_ring_mem.sv
// timestamp ring storage, one write and one registered read port
module swod_ring_mem #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic                              aclk,
    input  logic                              we,
    input  logic [ADDR_W-1:0]                 waddr,
    input  logic [swod_pkg::EVT_TIME_W-1:0]   wdata,
    input  logic [ADDR_W-1:0]                 raddr,
    output logic [swod_pkg::EVT_TIME_W-1:0]   rdata
);
    import swod_pkg::*;

    logic [EVT_TIME_W-1:0] mem [DEPTH];
    logic [EVT_TIME_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/swod_ctrl.sv
// sequencer: expiry walk over the ring, overload decision, push and result register
module swod_ctrl #(
    parameter int RING_DEPTH = 8,
    parameter int PTR_W      = 3,
    parameter int CNT_W      = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  swod_pkg::cfg_t                    cfg,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [swod_pkg::EVT_TIME_W-1:0]   s_event_time,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic [swod_pkg::RCOUNT_W-1:0]     m_recent_count,
    output logic                              mem_we,
    output logic [PTR_W-1:0]                  mem_waddr,
    output logic [swod_pkg::EVT_TIME_W-1:0]   mem_wdata,
    output logic [PTR_W-1:0]                  mem_raddr,
    input  logic [swod_pkg::EVT_TIME_W-1:0]   mem_rdata
);
    import swod_pkg::*;

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(RING_DEPTH);

    state_t                 state_reg, state_next;
    logic [EVT_TIME_W-1:0]  now_reg, now_next;
    logic [PTR_W-1:0]       oldest_reg, oldest_next;
    logic [PTR_W-1:0]       head_reg, head_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   kill_reg, kill_next;
    logic                   m_valid_reg, m_valid_next;
    status_t                m_status_reg, m_status_next;
    logic [RCOUNT_W-1:0]    m_count_reg, m_count_next;

    logic [EVT_TIME_W-1:0]  age;
    logic                   expired;
    logic                   out_free;
    logic [CNT_W-1:0]       cnt_inc;
    logic                   over;

    assign age      = now_reg - mem_rdata;
    assign expired  = age > {{(EVT_TIME_W-WINDOW_W){1'b0}}, cfg.window_length};
    assign out_free = !m_valid_reg || m_ready;
    assign cnt_inc  = count_reg + CNT_W'(1);
    assign over     = 32'(cnt_inc) > 32'(cfg.overload_limit);

    always_comb begin
        state_next    = state_reg;
        now_next      = now_reg;
        oldest_next   = oldest_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        kill_next     = kill_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;
        mem_we        = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    now_next   = s_event_time;
                    state_next = kill_reg ? S_DECIDE : S_CHECK;
                end
            end
            S_CHECK: begin
                if (count_reg != '0 && expired) begin
                    oldest_next = (oldest_reg == LAST_SLOT) ? '0 : oldest_reg + PTR_W'(1);
                    count_next  = count_reg - CNT_W'(1);
                end else begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                    if (kill_reg) begin
                        m_status_next = ST_IGNORED;
                        m_count_next  = RCOUNT_W'(count_reg);
                    end else if (count_reg == FULL_CNT) begin
                        kill_next     = 1'b1;
                        m_status_next = ST_KILLED;
                        m_count_next  = RCOUNT_W'(count_reg);
                    end else begin
                        mem_we        = 1'b1;
                        head_next     = (head_reg == LAST_SLOT) ? '0 : head_reg + PTR_W'(1);
                        count_next    = cnt_inc;
                        kill_next     = over;
                        m_status_next = over ? ST_KILLED : ST_RECORDED;
                        m_count_next  = RCOUNT_W'(cnt_inc);
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            oldest_reg  <= '0;
            head_reg    <= '0;
            count_reg   <= '0;
            kill_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            oldest_reg  <= oldest_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            kill_reg    <= kill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg      <= now_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
    end

    // read port always follows the oldest entry
    assign mem_raddr = oldest_next;
    assign mem_waddr = head_reg;
    assign mem_wdata = now_reg;

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_recent_count = m_count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("ring count above depth");

    a_kill_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        kill_reg |=> kill_reg)
        else $error("kill flag cleared");

    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |=> $stable(count_reg))
        else $error("count changed while idle");

    a_ignored: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DECIDE && kill_reg && out_free)
            |=> (m_valid_reg && m_status_reg == ST_IGNORED))
        else $error("killed beat not reported as ignored");

endmodule

// File: tb/sv/tb_sliding_window_overload_detector.sv
// testbench for the sliding window overload detector: directed and random event beats checked against a predictor
module tb_sliding_window_overload_detector;
    import swod_pkg::*;

    localparam int RING_SLOTS = 8;
    localparam int PTR_SPAN   = 2 * RING_SLOTS;

    localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW = {REG_WINDOW_LENGTH, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_LIMIT  = {REG_OVERLOAD_LIMIT, 2'b00};

    class overload_checker;
        logic [EVT_TIME_W-1:0] ring [RING_SLOTS];
        int unsigned           head = 0;
        int unsigned           tail = 0;
        bit                    killed = 1'b0;
        logic [WINDOW_W-1:0]   window = WINDOW_RESET;
        logic [LIMIT_W-1:0]    limit = LIMIT_RESET;
        status_t               status_due [$];
        logic [RCOUNT_W-1:0]   count_due [$];
        int unsigned           mismatches = 0;

        function int unsigned held();
            return (tail + PTR_SPAN - head) % PTR_SPAN;
        endfunction

        function logic [EVT_TIME_W-1:0] oldest_stamp();
            return ring[head % RING_SLOTS];
        endfunction

        function int unsigned pending();
            return status_due.size();
        endfunction

        function void flag(input string msg);
            if (mismatches < 10)
                $display("mismatch: %s", msg);
            mismatches++;
        endfunction

        function void advance_window(input logic [EVT_TIME_W-1:0] stamp, input bit commit,
                                     output status_t st, output logic [RCOUNT_W-1:0] cnt);
            int unsigned walk;
            int unsigned kept;
            walk = head;
            if (killed) begin
                st = ST_IGNORED;
                cnt = RCOUNT_W'(held());
                return;
            end
            // retire from the oldest end until an entry is still recent
            while (walk != tail && (stamp - ring[walk % RING_SLOTS]) > {32'd0, window})
                walk = (walk + 1) % PTR_SPAN;
            kept = (tail + PTR_SPAN - walk) % PTR_SPAN;
            if (kept >= RING_SLOTS) begin
                st = ST_KILLED;
                cnt = RCOUNT_W'(kept);
                if (commit) begin
                    head = walk;
                    killed = 1'b1;
                end
                return;
            end
            st = (kept + 1 > limit) ? ST_KILLED : ST_RECORDED;
            cnt = RCOUNT_W'(kept + 1);
            if (commit) begin
                ring[tail % RING_SLOTS] = stamp;
                tail = (tail + 1) % PTR_SPAN;
                head = walk;
                killed = (st == ST_KILLED);
            end
        endfunction

        function bit would_kill(input logic [EVT_TIME_W-1:0] stamp);
            status_t st;
            logic [RCOUNT_W-1:0] cnt;
            advance_window(stamp, 1'b0, st, cnt);
            return st == ST_KILLED;
        endfunction

        function void note_event(input logic [EVT_TIME_W-1:0] stamp);
            status_t st;
            logic [RCOUNT_W-1:0] cnt;
            advance_window(stamp, 1'b1, st, cnt);
            status_due.push_back(st);
            count_due.push_back(cnt);
        endfunction

        function void check_result(input logic [1:0] st, input logic [RCOUNT_W-1:0] cnt);
            status_t want_st;
            logic [RCOUNT_W-1:0] want_cnt;
            if (status_due.size() == 0) begin
                flag($sformatf("unexpected result beat, status %0d count %0d", st, cnt));
                return;
            end
            want_st = status_due.pop_front();
            want_cnt = count_due.pop_front();
            if (st !== want_st || cnt !== want_cnt)
                flag($sformatf("expected status %0d count %0d, got status %0d count %0d",
                               want_st, want_cnt, st, cnt));
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [EVT_TIME_W-1:0] s_event_time = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [1:0]            m_status;
    logic [RCOUNT_W-1:0]   m_recent_count;

    overload_checker       sb;
    bit                    calm = 1'b0;
    logic [EVT_TIME_W-1:0] now_base = '0;

    logic [EVT_TIME_W-1:0] directed_stamps [13] = '{
        64'h0000_0000_0000_0000, 64'h0000_0000_0000_03E8, 64'h0000_0000_0000_03E9,
        64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_01F4, 64'h0000_0000_0000_01F4,
        64'h8000_0000_0000_0000, 64'h8000_0000_0000_03E8, 64'h7FFF_FFFF_FFFF_FFFF,
        64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0002,
        64'h8000_0000_0000_03E9
    };

    sliding_window_overload_detector #(
        .RING_DEPTH(RING_SLOTS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_event_time(s_event_time),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_recent_count(m_recent_count)
    );

    always #6 aclk = ~aclk;

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_read(input logic [APB_ADDR_W-1:0] addr,
                            output logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_config(input logic [WINDOW_W-1:0] w, input logic [LIMIT_W-1:0] l);
        logic [APB_DATA_W-1:0] rd;
        apb_write(ADDR_WINDOW, w);
        apb_write(ADDR_LIMIT, APB_DATA_W'(l));
        sb.window = w;
        sb.limit = l;
        apb_read(ADDR_WINDOW, rd);
        if (rd !== w)
            sb.flag($sformatf("window_length reads %0d, written %0d", rd, w));
        apb_read(ADDR_LIMIT, rd);
        if (rd[LIMIT_W-1:0] !== l)
            sb.flag($sformatf("overload_limit reads %0d, written %0d", rd[LIMIT_W-1:0], l));
    endtask

    task automatic send_event(input logic [EVT_TIME_W-1:0] stamp);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_event_time <= stamp;
        do @(posedge aclk); while (!s_ready);
        sb.note_event(stamp);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // mostly advancing timestamps spaced against the window, steered away from a kill by up to 16 redraws
    task automatic run_phase(input int unsigned n_items);
        logic [EVT_TIME_W-1:0] stamp;
        logic [EVT_TIME_W-1:0] w;
        int unsigned pick;
        int unsigned tries;
        w = {32'd0, sb.window};
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                stamp = now_base + (w * $urandom_range(0, 24)) / 32;
            else if (pick < 65 && sb.held() != 0)
                stamp = sb.oldest_stamp() + w + $urandom_range(0, 1);
            else if (pick < 80)
                stamp = now_base + w + 1 + $urandom_range(0, 3000);
            else if (pick < 90)
                stamp = {$urandom, $urandom};
            else if (pick < 95)
                stamp = now_base - $urandom_range(0, 2000);
            else
                stamp = now_base;
            if (sb.would_kill(stamp) && sb.held() != 0)
                stamp = sb.oldest_stamp() + w + 1;
            tries = 0;
            while (sb.would_kill(stamp) && tries < 16) begin
                stamp = {$urandom, $urandom};
                tries++;
            end
            now_base = stamp;
            send_event(stamp);
        end
    endtask

    initial begin
        int unsigned stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_status, m_recent_count);
        end
    end

    initial begin
        #(64'd4_800_000);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [WINDOW_W-1:0] w;
        logic [LIMIT_W-1:0]  l;
        int unsigned         tries;
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // boundary ages, wrap of the timestamp, fully expired ring
        foreach (directed_stamps[i])
            send_event(directed_stamps[i]);
        now_base = directed_stamps[12];
        drain();

        for (int p = 0; p < 10; p++) begin
            case (p)
                0: begin
                    w = '0;
                    l = 3'd7;
                end
                1: begin
                    w = 32'hFFFF_FFFF;
                    l = 3'd1;
                end
                2: begin
                    w = 32'hFFFF_FFFF;
                    l = 3'd7;
                end
                3: begin
                    w = 32'd1;
                    l = LIMIT_W'($urandom_range(1, 7));
                end
                default: begin
                    w = $urandom_range(0, 1) ? $urandom_range(1, 5000) : $urandom;
                    l = LIMIT_W'($urandom_range(1, 7));
                end
            endcase
            write_config(w, l);
            calm = ($urandom_range(0, 3) == 0);
            run_phase(180);
            drain();
        end

        // the kill is sticky, so it comes last
        calm = 1'b0;
        if ($urandom_range(0, 1)) begin
            write_config(sb.window, '0);
            send_event({$urandom, $urandom});
        end else begin
            tries = 0;
            while (!sb.killed && tries < 16) begin
                send_event(now_base);
                tries++;
            end
        end
        drain();

        write_config($urandom, '0);
        for (int i = 0; i < 30; i++) begin
            if ($urandom_range(0, 1))
                send_event({$urandom, $urandom});
            else
                send_event(now_base + $urandom_range(0, 2000));
        end
        drain();

        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
